// ===== sv/integer_calculator_alu_assert.svh =====
// assertion macros for the integer calculator alu
// used by integer_calculator_alu; no other dependencies
`ifndef INTEGER_CALCULATOR_ALU_ASSERT_SVH
`define INTEGER_CALCULATOR_ALU_ASSERT_SVH
`ifndef ASSERT_OFF
`define ICA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("integer_calculator_alu: assertion failed");
`define ICA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("integer_calculator_alu: assertion failed");
`else
`define ICA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ICA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ica_pkg.sv =====
// shared types, codes and the factorial table for the integer calculator alu
// no dependencies
`timescale 1ns / 1ps

package ica_pkg;

    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(DATA_W);
    localparam int FACT_MAX = 12;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_POW   = 3'd4,
        CMD_FACT  = 3'd5,
        CMD_UNK_A = 3'd6,
        CMD_UNK_B = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIV0    = 2'd1,
        ST_FACT    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    // factorial of 0..12, anything else is never looked up
    function automatic logic [DATA_W-1:0] fact_lookup(input logic [3:0] n);
        logic [DATA_W-1:0] v;
        case (n)
            4'd0:    v = 32'd1;
            4'd1:    v = 32'd1;
            4'd2:    v = 32'd2;
            4'd3:    v = 32'd6;
            4'd4:    v = 32'd24;
            4'd5:    v = 32'd120;
            4'd6:    v = 32'd720;
            4'd7:    v = 32'd5040;
            4'd8:    v = 32'd40320;
            4'd9:    v = 32'd362880;
            4'd10:   v = 32'd3628800;
            4'd11:   v = 32'd39916800;
            4'd12:   v = 32'd479001600;
            default: v = '1;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ica_div.sv =====
// iterative restoring signed divider, one quotient bit per cycle
// depends on ica_pkg
`timescale 1ns / 1ps

module ica_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ica_pkg::DATA_W-1:0]   i_dividend,
    input  logic [ica_pkg::DATA_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [ica_pkg::DATA_W-1:0]   o_quotient
);

    localparam logic [ica_pkg::CNT_W-1:0] CNT_LAST = ica_pkg::CNT_W'(ica_pkg::DATA_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [ica_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_neg;
    logic [ica_pkg::DATA_W-1:0]    r_rem;
    logic [ica_pkg::DATA_W-1:0]    r_quo;
    logic [ica_pkg::DATA_W-1:0]    r_dvs;

    logic                          w_a_neg;
    logic                          w_b_neg;
    logic [ica_pkg::DATA_W-1:0]    w_shift;
    logic [ica_pkg::DATA_W:0]      w_trial;

    assign w_a_neg = i_dividend[ica_pkg::DATA_W-1];
    assign w_b_neg = i_divisor[ica_pkg::DATA_W-1];

    // remainder stays below the divisor magnitude, so the shift fits
    assign w_shift = {r_rem[ica_pkg::DATA_W-2:0], r_quo[ica_pkg::DATA_W-1]};
    assign w_trial = {1'b0, w_shift} - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= w_a_neg ^ w_b_neg;
                r_rem  <= '0;
                r_quo  <= w_a_neg ? (~i_dividend + 1'b1) : i_dividend;
                r_dvs  <= w_b_neg ? (~i_divisor + 1'b1) : i_divisor;
            end else if (r_busy) begin
                if (!w_trial[ica_pkg::DATA_W]) begin
                    r_rem <= w_trial[ica_pkg::DATA_W-1:0];
                    r_quo <= {r_quo[ica_pkg::DATA_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[ica_pkg::DATA_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

// ===== sv/integer_calculator_alu.sv =====
// integer calculator alu: add, sub, mul, div, power, factorial
// one shared 32x32 multiplier under a small sequencer, plus ica_div
// depends on ica_pkg, ica_div and integer_calculator_alu_assert.svh
//
// usage:
//   request channel i_valid/o_ready carries i_cmd, i_lhs, i_rhs; the result
//   channel o_valid/i_ready carries o_value and o_status. one result per request.
//   path from request to o_valid, with the receiver ready:
//     add, sub, factorial, unknown code and power special cases: S_DONE only
//     multiply: S_MUL (one pass through the shared multiplier), then S_DONE
//     divide: S_DIV (32 restoring steps in ica_div), then S_DONE; zero divisor S_DONE
//     power: S_POW_A and S_POW_S per exponent bit up to its top set bit, then
//     S_DONE, since each exponent bit takes two multiplier passes.
//   o_ready is high only while the sequencer is idle, so one request is worked
//   at a time. a finished result sits in the output register; the next request
//   is taken while it waits, and its own result waits inside until i_ready
//   frees the output register.
//   reset (synchronous, active low) drops o_valid and returns to idle.
`timescale 1ns / 1ps
`include "integer_calculator_alu_assert.svh"

module integer_calculator_alu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_cmd,
    input  logic signed [31:0]           i_lhs,
    input  logic signed [31:0]           i_rhs,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [31:0]           o_value,
    output logic [1:0]                   o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_POW_A,
        S_POW_S,
        S_DIV,
        S_DONE
    } t_state;

    t_state                         r_state;
    logic [ica_pkg::DATA_W-1:0]     r_acc;
    logic [ica_pkg::DATA_W-1:0]     r_sq;
    logic [ica_pkg::DATA_W-2:0]     r_ex;
    ica_pkg::t_status               r_res_st;
    logic                           r_div_start;
    logic                           r_out_valid;
    logic [ica_pkg::DATA_W-1:0]     r_value;
    ica_pkg::t_status               r_status;

    logic [ica_pkg::DATA_W-1:0]     w_mul_a;
    logic [ica_pkg::DATA_W-1:0]     w_prod;
    logic                           w_div_done;
    logic [ica_pkg::DATA_W-1:0]     w_div_quo;
    logic                           w_accept;
    logic                           w_fact_ok;
    logic [ica_pkg::DATA_W-1:0]     w_lhs;
    logic [ica_pkg::DATA_W-1:0]     w_rhs;

    assign w_lhs    = i_lhs;
    assign w_rhs    = i_rhs;
    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_fact_ok = (w_lhs[ica_pkg::DATA_W-1:4] == '0)
                    && (w_lhs[3:0] <= 4'(ica_pkg::FACT_MAX));

    // shared multiplier: squaring pass uses sq twice, otherwise acc * sq
    assign w_mul_a = (r_state == S_POW_S) ? r_sq : r_acc;
    assign w_prod  = w_mul_a * r_sq;

    ica_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_sq),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            // in S_DONE the output register is handled by the state itself
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_st <= ica_pkg::ST_OK;
                        r_state  <= S_DONE;
                        case (ica_pkg::t_cmd'(i_cmd))
                            ica_pkg::CMD_ADD: begin
                                r_acc <= w_lhs + w_rhs;
                            end
                            ica_pkg::CMD_SUB: begin
                                r_acc <= w_lhs - w_rhs;
                            end
                            ica_pkg::CMD_MUL: begin
                                r_acc   <= w_lhs;
                                r_sq    <= w_rhs;
                                r_state <= S_MUL;
                            end
                            ica_pkg::CMD_DIV: begin
                                if (w_rhs == '0) begin
                                    r_acc    <= '0;
                                    r_res_st <= ica_pkg::ST_DIV0;
                                end else begin
                                    r_acc       <= w_lhs;
                                    r_sq        <= w_rhs;
                                    r_div_start <= 1'b1;
                                    r_state     <= S_DIV;
                                end
                            end
                            ica_pkg::CMD_POW: begin
                                if (w_lhs == 32'd1 || w_rhs == '0) begin
                                    r_acc <= 32'd1;
                                end else if (w_lhs == '0) begin
                                    r_acc <= '0;
                                end else if (w_rhs[ica_pkg::DATA_W-1]) begin
                                    r_acc <= 32'd1;
                                end else begin
                                    r_acc   <= 32'd1;
                                    r_sq    <= w_lhs;
                                    r_ex    <= w_rhs[ica_pkg::DATA_W-2:0];
                                    r_state <= S_POW_A;
                                end
                            end
                            ica_pkg::CMD_FACT: begin
                                if (w_fact_ok) begin
                                    r_acc <= ica_pkg::fact_lookup(w_lhs[3:0]);
                                end else begin
                                    r_acc    <= '1;
                                    r_res_st <= ica_pkg::ST_FACT;
                                end
                            end
                            default: begin
                                r_acc    <= '1;
                                r_res_st <= ica_pkg::ST_UNKNOWN;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_acc   <= w_prod;
                    r_state <= S_DONE;
                end
                S_POW_A: begin
                    if (r_ex[0]) begin
                        r_acc <= w_prod;
                    end
                    r_state <= S_POW_S;
                end
                S_POW_S: begin
                    r_sq <= w_prod;
                    r_ex <= r_ex >> 1;
                    // stop once no exponent bits remain above this one
                    if (r_ex[ica_pkg::DATA_W-2:1] == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_POW_A;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_acc   <= w_div_quo;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_value     <= r_acc;
                        r_status    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

    `ICA_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    `ICA_ASSERT_NEXT(a_request_leaves_idle, i_clk, i_rst_n, w_accept, !o_ready)
    `ICA_ASSERT_IMP(a_error_value, i_clk, i_rst_n,
                    o_valid && o_status != ica_pkg::ST_OK, o_value == '1 || o_value == '0)
    `ICA_ASSERT_IMP(a_pow_exp_live, i_clk, i_rst_n, r_state == S_POW_A, r_ex != '0)

endmodule
